### hdl/idu_pkg.sv
// ----------------------------------------------------------------------------
// idu_pkg: shared types and constants for the interrupt dispatch unit
// Word layouts, action and mode codes, vector table and the priority helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package idu_pkg;

  localparam int unsigned NUM_IRQ = 5;

  localparam logic [4:0]  PEND_MASK    = 5'h1F;
  localparam logic [15:0] VEC_BASE     = 16'h0040;
  localparam logic [15:0] VEC_CANCEL   = 16'h0000;
  localparam logic [15:0] SP_WRAP_HIT  = 16'h0000;  // SP-1 lands on 0xFFFF (IE)
  localparam logic [15:0] PUSH_BYTES   = 16'd2;
  localparam logic [4:0]  CYC_DISPATCH = 5'd20;
  localparam logic [4:0]  CYC_HALT     = 5'd4;
  localparam logic [4:0]  CYC_NONE     = 5'd0;
  localparam logic [1:0]  EI_ARM       = 2'd2;

  typedef enum logic [1:0] {
    MODE_STEP = 2'd0,
    MODE_DONE = 2'd1,
    MODE_EI   = 2'd2,
    MODE_HALT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ACT_FETCH    = 3'd0,
    ACT_FETCH_NI = 3'd1,
    ACT_HALT     = 3'd2,
    ACT_DISPATCH = 3'd3,
    ACT_CANCEL   = 3'd4,
    ACT_ACK      = 3'd5
  } action_t;

  typedef struct packed {
    mode_t       mode;
    logic [4:0]  flag_bits;
    logic [7:0]  enable_bits;
    logic [15:0] program_counter;
    logic [15:0] stack_pointer;
    logic        bug_on_halt;
  } item_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] next_pc;
    logic [15:0] next_sp;
    logic [4:0]  flag_clear_mask;
    logic        enable_overwritten;
    logic [7:0]  new_enable;
    logic [4:0]  cycle_count;
    logic        master_enable;
  } result_t;

  typedef struct packed {
    logic       ime;
    logic       halted;
    logic       halt_bug;
    logic [1:0] ei_delay;
  } state_t;

  // Lowest set bit, one-hot; zero when nothing is set.
  function automatic logic [4:0] lowest_bit(input logic [4:0] p);
    logic [4:0] r;
    r = '0;
    for (int i = NUM_IRQ - 1; i >= 0; i--) begin
      if (p[i]) r = 5'(1 << i);
    end
    return r;
  endfunction

  // Vector 0x40 + 8*index for a one-hot request, 0x0000 for none.
  function automatic logic [15:0] vector_of(input logic [4:0] onehot);
    logic [15:0] v;
    v = VEC_CANCEL;
    for (int i = 0; i < NUM_IRQ; i++) begin
      if (onehot[i]) v = VEC_BASE + (16'(i) << 3);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### hdl/idu_step.sv
// ----------------------------------------------------------------------------
// idu_step: single-pass step logic
// Combinational result and next state for one word against the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module idu_step (
  input  idu_pkg::item_t   item,
  input  idu_pkg::state_t  st,
  output idu_pkg::result_t res,
  output idu_pkg::state_t  st_next
);
  import idu_pkg::*;

  logic [4:0] pending;
  logic [4:0] post;
  logic [4:0] sel;

  always_comb begin
    res.action             = ACT_ACK;
    res.next_pc            = item.program_counter;
    res.next_sp            = item.stack_pointer;
    res.flag_clear_mask    = '0;
    res.enable_overwritten = 1'b0;
    res.new_enable         = item.enable_bits;
    res.cycle_count        = CYC_NONE;
    st_next                = st;
    pending                = item.flag_bits & item.enable_bits[4:0] & PEND_MASK;
    post                   = '0;
    sel                    = '0;

    case (item.mode)
      MODE_STEP: begin
        if (pending != '0) st_next.halted = 1'b0;
        if (pending != '0 && st.ime) begin
          st_next.ime = 1'b0;
          sel = lowest_bit(pending);
          // High byte push onto IE: re-pick from the new enable value
          if (item.stack_pointer == SP_WRAP_HIT) begin
            res.enable_overwritten = 1'b1;
            res.new_enable         = item.program_counter[15:8];
            post = item.flag_bits & item.program_counter[12:8] & PEND_MASK;
            if ((post & sel) == '0) sel = lowest_bit(post);
          end
          res.next_sp     = item.stack_pointer - PUSH_BYTES;
          res.cycle_count = CYC_DISPATCH;
          if (sel != '0) begin
            res.action          = ACT_DISPATCH;
            res.next_pc         = vector_of(sel);
            res.flag_clear_mask = sel;
          end else begin
            res.action  = ACT_CANCEL;
            res.next_pc = VEC_CANCEL;
          end
        end else if (st_next.halted) begin
          // a pending request has already woken the CPU above
          res.action      = ACT_HALT;
          res.cycle_count = CYC_HALT;
        end else if (st.halt_bug) begin
          res.action       = ACT_FETCH_NI;
          st_next.halt_bug = 1'b0;
        end else begin
          res.action  = ACT_FETCH;
          res.next_pc = item.program_counter + 16'd1;
        end
      end
      MODE_DONE: begin
        if (st.ei_delay != 2'd0) begin
          st_next.ei_delay = st.ei_delay - 2'd1;
          if (st.ei_delay == 2'd1) st_next.ime = 1'b1;
        end
      end
      MODE_EI: begin
        if (st.ei_delay == 2'd0) st_next.ei_delay = EI_ARM;
      end
      MODE_HALT: begin
        if (item.bug_on_halt) st_next.halt_bug = 1'b1;
        else                  st_next.halted   = 1'b1;
      end
      default: begin
        st_next = st;
      end
    endcase

    res.master_enable = st_next.ime;
  end

endmodule

`default_nettype wire

### hdl/interrupt_dispatch_unit_top.sv
// ----------------------------------------------------------------------------
// interrupt_dispatch_unit_top: interrupt and halt front end
// Input register, single-pass step logic, result register; holds IME, HALT,
// halt-bug and EI delay state.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in      | to unit   | in_valid / in_stall | mode, flag_bits, enable_bits,
//          |           |                     | program_counter, stack_pointer,
//          |           |                     | bug_on_halt
//  out     | from unit | out_valid/out_stall | action, next_pc, next_sp,
//          |           |                     | flag_clear_mask, enable_overwritten,
//          |           |                     | new_enable, cycle_count, master_enable
//
//  One word per cycle sustained while out_stall is low; a word passes the input
//  register, then the result register. The step logic reads and updates the
//  state register as a word moves from the input into the result register.
//  Reset (rst, synchronous) empties both registers and clears IME, HALT,
//  halt-bug and the EI delay.
//  out_stall holds the result register; the input register still fills, and
//  in_stall rises only when both registers are full and the result is held.
// ----------------------------------------------------------------------------
`default_nettype none

module interrupt_dispatch_unit_top (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [4:0]  flag_bits,
  input  logic [7:0]  enable_bits,
  input  logic [15:0] program_counter,
  input  logic [15:0] stack_pointer,
  input  logic        bug_on_halt,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [15:0] next_pc,
  output logic [15:0] next_sp,
  output logic [4:0]  flag_clear_mask,
  output logic        enable_overwritten,
  output logic [7:0]  new_enable,
  output logic [4:0]  cycle_count,
  output logic        master_enable
);
  import idu_pkg::*;

  // input register
  logic    s1_valid;
  item_t   s1;
  // result register
  result_t res;
  // architectural state
  state_t  state;

  result_t res_next;
  state_t  state_next;
  logic    s1_adv;
  logic    in_accept;
  logic    out_take;

  assign out_take  = out_valid && !out_stall;
  assign s1_adv    = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  idu_step u_step (
    .item    (s1),
    .st      (state),
    .res     (res_next),
    .st_next (state_next)
  );

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (in_accept)   s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;

      if (s1_adv)        out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;

      if (s1_adv) state <= state_next;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1.mode            <= mode_t'(mode);
      s1.flag_bits       <= flag_bits;
      s1.enable_bits     <= enable_bits;
      s1.program_counter <= program_counter;
      s1.stack_pointer   <= stack_pointer;
      s1.bug_on_halt     <= bug_on_halt;
    end
    if (s1_adv) res <= res_next;
  end

  assign action             = res.action;
  assign next_pc            = res.next_pc;
  assign next_sp            = res.next_sp;
  assign flag_clear_mask    = res.flag_clear_mask;
  assign enable_overwritten = res.enable_overwritten;
  assign new_enable         = res.new_enable;
  assign cycle_count        = res.cycle_count;
  assign master_enable      = res.master_enable;

  // EI delay only ever holds 0, 1 or 2
  a_ei_range: assert property (@(posedge clk) disable iff (rst)
    state.ei_delay != 2'd3)
    else $error("EI delay out of range");

  // a served interrupt drops IME, clears exactly one IF bit and reports CYC_DISPATCH
  a_dispatch: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.action == ACT_DISPATCH |->
      !master_enable && $onehot(flag_clear_mask) && cycle_count == CYC_DISPATCH)
    else $error("dispatch result inconsistent");

  // a cancelled dispatch only follows a push onto IE
  a_cancel: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.action == ACT_CANCEL |->
      enable_overwritten && next_pc == VEC_CANCEL && flag_clear_mask == '0)
    else $error("cancel result inconsistent");

  // the input side stalls only with a word waiting behind a held result
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("unexpected input stall");

  // a held result keeps the state frozen when nothing advances
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> $stable(state))
    else $error("state changed without a word advancing");

endmodule

`default_nettype wire
